// File: rtl/ubh_pkg.sv
// Shared types and codes for the uniform-bin histogram.
`default_nettype none
package ubh_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START  = 2'd0,
        CFG_FINISH = 2'd1,
        CFG_BINS   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLS_IN    = 2'd0,
        CLS_BELOW = 2'd1,
        CLS_ABOVE = 2'd2
    } sample_class_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CLASS,
        F_MUL,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } back_state_t;

    // per-request control carried from front to back
    typedef struct packed {
        logic          is_read;
        logic          hit;
        logic          err;
        sample_class_t cls;
    } req_flags_t;

    localparam int FLAGS_W = $bits(req_flags_t);

endpackage
`default_nettype wire

// File: rtl/ubh_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none
module ubh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/ubh_front.sv
// Front end: accepts requests, classifies samples and finds the bin by iterative division.
`default_nettype none
module ubh_front #(
    parameter int SW = 32,
    parameter int IW = 10,
    parameter int BW = 11
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [SW-1:0]        s_sample,
    input  wire logic [IW-1:0]        s_ridx,
    input  wire logic                 clr_busy,
    input  wire logic [SW-1:0]        cfg_start,
    input  wire logic [SW-1:0]        cfg_finish,
    input  wire logic [BW-1:0]        n_eff,
    output logic                      push_valid,
    output ubh_pkg::req_flags_t       push_flags,
    output logic      [IW-1:0]        push_idx,
    input  wire logic                 q_full
);
    import ubh_pkg::*;

    localparam int PW  = BW + SW + 1;
    localparam int BCW = $clog2(BW);

    front_state_t     state_reg, state_next;
    logic             op_reg, op_next;
    logic [SW-1:0]    samp_reg, samp_next;
    logic [IW-1:0]    idx_reg, idx_next;
    req_flags_t       flags_reg, flags_next;
    logic [SW:0]      a_reg, a_next;
    logic [SW:0]      d_reg, d_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [BW-1:0]    q_reg, q_next;
    logic [BCW-1:0]   bit_reg, bit_next;

    logic signed [SW-1:0] s_sg, st_sg, fi_sg;
    logic [PW-1:0]        shifted;
    logic [IW-1:0]        last_bin;

    assign s_sg     = $signed(samp_reg);
    assign st_sg    = $signed(cfg_start);
    assign fi_sg    = $signed(cfg_finish);
    assign shifted  = PW'(d_reg) << bit_reg;
    assign last_bin = IW'(n_eff - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg    <= op_next;
        samp_reg  <= samp_next;
        idx_reg   <= idx_next;
        flags_reg <= flags_next;
        a_reg     <= a_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        samp_next  = samp_reg;
        idx_next   = idx_reg;
        flags_next = flags_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        push_flags = flags_reg;
        push_idx   = idx_reg;
        case (state_reg)
            F_IDLE: begin
                s_ready = !clr_busy;
                if (s_valid && !clr_busy) begin
                    op_next    = s_op;
                    samp_next  = s_sample;
                    idx_next   = s_ridx;
                    state_next = F_CLASS;
                end
            end
            F_CLASS: begin
                flags_next = '{is_read: 1'b0, hit: 1'b0, err: 1'b0, cls: CLS_IN};
                state_next = F_PUSH;
                if (op_reg) begin
                    flags_next.is_read = 1'b1;
                    flags_next.err     = BW'(idx_reg) >= n_eff;
                end else if (s_sg == st_sg) begin
                    flags_next.hit = 1'b1;
                    idx_next       = '0;
                end else if (s_sg < st_sg) begin
                    flags_next.cls = CLS_BELOW;
                    idx_next       = '0;
                end else if (s_sg > fi_sg) begin
                    flags_next.cls = CLS_ABOVE;
                    idx_next       = '0;
                end else if (s_sg == fi_sg) begin
                    flags_next.hit = 1'b1;
                    idx_next       = last_bin;
                end else begin
                    // start < sample < finish: bin = floor(n*(s-start)/(finish-start))
                    flags_next.hit = 1'b1;
                    a_next     = {samp_reg[SW-1], samp_reg} - {cfg_start[SW-1], cfg_start};
                    d_next     = {cfg_finish[SW-1], cfg_finish} - {cfg_start[SW-1], cfg_start};
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                rem_next   = PW'(n_eff) * PW'(a_reg);
                q_next     = '0;
                bit_next   = BCW'(BW - 1);
                state_next = F_DIV;
            end
            F_DIV: begin
                if (rem_reg >= shifted) begin
                    rem_next         = rem_reg - shifted;
                    q_next[bit_reg]  = 1'b1;
                end
                if (bit_reg == '0) begin
                    idx_next   = (q_next >= n_eff) ? last_bin : IW'(q_next);
                    state_next = F_PUSH;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/ubh_queue.sv
// Two-entry request queue between front and back.
`default_nettype none
module ubh_queue #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              nonempty,
    output logic      [W-1:0] head
);
    logic [W-1:0] mem_reg [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   cnt_reg;
    logic         do_push, do_pop;

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign head     = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wr_reg <= !wr_reg;
            end
            if (do_pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// File: rtl/ubh_back.sv
// Back end: clears the bin store, updates counters and holds the result register.
`default_nettype none
module ubh_back #(
    parameter int MAX_BINS = 1024,
    parameter int CW       = 32,
    parameter int IW       = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_nonempty,
    input  wire ubh_pkg::req_flags_t   q_flags,
    input  wire logic [IW-1:0]         q_idx,
    output logic                       q_pop,
    output logic                       clr_busy,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ubh_pkg::sample_class_t     m_cls,
    output logic      [IW-1:0]         m_chosen,
    output logic      [CW-1:0]         m_total,
    output logic      [CW-1:0]         m_below,
    output logic      [CW-1:0]         m_above,
    output logic      [CW-1:0]         m_peak,
    output logic                       m_err
);
    import ubh_pkg::*;

    back_state_t   state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    req_flags_t    cur_reg, cur_next;
    logic [IW-1:0] cidx_reg, cidx_next;
    logic [CW-1:0] below_reg, below_next;
    logic [CW-1:0] above_reg, above_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic          mv_reg, mv_next;
    sample_class_t ocls_reg, ocls_next;
    logic [IW-1:0] ochosen_reg, ochosen_next;
    logic [CW-1:0] ototal_reg, ototal_next;
    logic [CW-1:0] obelow_reg, obelow_next;
    logic [CW-1:0] oabove_reg, oabove_next;
    logic [CW-1:0] opeak_reg, opeak_next;
    logic          oerr_reg, oerr_next;

    logic          we, re;
    logic [IW-1:0] waddr, raddr;
    logic [CW-1:0] wdata, rdata, incd;

    ubh_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign incd     = (&rdata) ? rdata : rdata + 1'b1;
    assign clr_busy = state_reg == B_CLEAR;
    assign m_valid  = mv_reg;
    assign m_cls    = ocls_reg;
    assign m_chosen = ochosen_reg;
    assign m_total  = ototal_reg;
    assign m_below  = obelow_reg;
    assign m_above  = oabove_reg;
    assign m_peak   = opeak_reg;
    assign m_err    = oerr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            below_reg <= '0;
            above_reg <= '0;
            peak_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            below_reg <= below_next;
            above_reg <= above_next;
            peak_reg  <= peak_next;
            mv_reg    <= mv_next;
        end
        cur_reg     <= cur_next;
        cidx_reg    <= cidx_next;
        ocls_reg    <= ocls_next;
        ochosen_reg <= ochosen_next;
        ototal_reg  <= ototal_next;
        obelow_reg  <= obelow_next;
        oabove_reg  <= oabove_next;
        opeak_reg   <= opeak_next;
        oerr_reg    <= oerr_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        cidx_next    = cidx_reg;
        below_next   = below_reg;
        above_next   = above_reg;
        peak_next    = peak_reg;
        mv_next      = mv_reg;
        ocls_next    = ocls_reg;
        ochosen_next = ochosen_reg;
        ototal_next  = ototal_reg;
        obelow_next  = obelow_reg;
        oabove_next  = oabove_reg;
        opeak_next   = opeak_reg;
        oerr_next    = oerr_reg;
        we    = 1'b0;
        waddr = cidx_reg;
        wdata = incd;
        re    = 1'b0;
        raddr = q_idx;
        q_pop = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            B_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(MAX_BINS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                // result register must be free by the time the read data returns
                if (q_nonempty && (!mv_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    re         = 1'b1;
                    cur_next   = q_flags;
                    cidx_next  = q_idx;
                    state_next = B_EXEC;
                end
            end
            B_EXEC: begin
                ocls_next    = cur_reg.cls;
                ochosen_next = cidx_reg;
                ototal_next  = '0;
                oerr_next    = cur_reg.err;
                if (cur_reg.is_read) begin
                    if (!cur_reg.err) begin
                        ototal_next = rdata;
                    end
                end else if (cur_reg.hit) begin
                    we          = 1'b1;
                    ototal_next = incd;
                    if (incd > peak_reg) begin
                        peak_next = incd;
                    end
                end else if (cur_reg.cls == CLS_BELOW) begin
                    if (!(&below_reg)) begin
                        below_next = below_reg + 1'b1;
                    end
                end else begin
                    if (!(&above_reg)) begin
                        above_next = above_reg + 1'b1;
                    end
                end
                obelow_next = below_next;
                oabove_next = above_next;
                opeak_next  = peak_next;
                mv_next     = 1'b1;
                state_next  = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/uniform_bin_histogram.sv
// Top level of the uniform-bin histogram with underflow and overflow counters.
//
//  port group   dir  tdata / tuser contents
//  s_*          in   tdata: sample, read_index | tuser: operation
//  m_*          out  tdata: chosen_bin, bin_total, below_total, above_total,
//                           peak_total, index_error | tuser: sample_class
//  cfg_*        in   write enable, register index, data
//
// A read, an out-of-range add or an add on a range edge passes the class and push states,
// the queue and the back end's execute state to the output register; any other add also
// passes the multiply state and the bit-a-cycle division over BW quotient bits (BW = bits
// of MAX_BINS+1). The divider and the read-modify-write of the bin store set the pace.
// After reset all MAX_BINS entries of the bin store are cleared; s_tready stays low then.
// A stalled result waits in the output register while the front takes the next request.
`default_nettype none
module uniform_bin_histogram #(
    parameter int MAX_BINS     = 1024,
    parameter int COUNT_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // sample, read_index
    input  wire logic [((SAMPLE_WIDTH+$clog2(MAX_BINS)+7)/8)*8-1:0] s_tdata,
    // operation
    input  wire logic [0:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // chosen_bin, bin_total, below_total, above_total, peak_total, index_error
    output logic [(($clog2(MAX_BINS)+4*COUNT_WIDTH+1+7)/8)*8-1:0] m_tdata,
    // sample_class
    output logic [1:0]                                 m_tuser,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ubh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [(SAMPLE_WIDTH > $clog2(MAX_BINS+1) ?
                        SAMPLE_WIDTH : $clog2(MAX_BINS+1))-1:0] cfg_data
);
    import ubh_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int IW = $clog2(MAX_BINS);
    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int QW = FLAGS_W + IW;
    localparam int O_TOT = IW;
    localparam int O_BEL = IW + CW;
    localparam int O_ABV = IW + 2 * CW;
    localparam int O_PK  = IW + 3 * CW;
    localparam int O_ERR = IW + 4 * CW;

    logic [SW-1:0] start_reg, finish_reg;
    logic [BW-1:0] bins_reg;
    logic [BW-1:0] n_eff;

    logic          clr_busy, push_valid, q_full, q_nonempty, q_pop;
    req_flags_t    push_flags, q_flags;
    logic [IW-1:0] push_idx, q_idx;
    logic [QW-1:0] q_head;

    sample_class_t o_cls;
    logic [IW-1:0] o_chosen;
    logic [CW-1:0] o_total, o_below, o_above, o_peak;
    logic          o_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            finish_reg <= SW'(65536);
            bins_reg   <= BW'(1024);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START:  start_reg  <= cfg_data[SW-1:0];
                CFG_FINISH: finish_reg <= cfg_data[SW-1:0];
                CFG_BINS:   bins_reg   <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (bins_reg == '0) begin
            n_eff = BW'(1);
        end else if (bins_reg > BW'(MAX_BINS)) begin
            n_eff = BW'(MAX_BINS);
        end else begin
            n_eff = bins_reg;
        end
    end

    ubh_front #(.SW(SW), .IW(IW), .BW(BW)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_op       (s_tuser[0]),
        .s_sample   (s_tdata[SW-1:0]),
        .s_ridx     (s_tdata[SW+IW-1:SW]),
        .clr_busy   (clr_busy),
        .cfg_start  (start_reg),
        .cfg_finish (finish_reg),
        .n_eff      (n_eff),
        .push_valid (push_valid),
        .push_flags (push_flags),
        .push_idx   (push_idx),
        .q_full     (q_full)
    );

    ubh_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data ({push_flags, push_idx}),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    assign q_flags = req_flags_t'(q_head[QW-1:IW]);
    assign q_idx   = q_head[IW-1:0];

    ubh_back #(.MAX_BINS(MAX_BINS), .CW(CW), .IW(IW)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_nonempty),
        .q_flags    (q_flags),
        .q_idx      (q_idx),
        .q_pop      (q_pop),
        .clr_busy   (clr_busy),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_cls      (o_cls),
        .m_chosen   (o_chosen),
        .m_total    (o_total),
        .m_below    (o_below),
        .m_above    (o_above),
        .m_peak     (o_peak),
        .m_err      (o_err)
    );

    always_comb begin
        m_tdata                    = '0;
        m_tdata[IW-1:0]            = o_chosen;
        m_tdata[O_TOT+CW-1:O_TOT]  = o_total;
        m_tdata[O_BEL+CW-1:O_BEL]  = o_below;
        m_tdata[O_ABV+CW-1:O_ABV]  = o_above;
        m_tdata[O_PK+CW-1:O_PK]    = o_peak;
        m_tdata[O_ERR]             = o_err;
    end
    assign m_tuser = o_cls;

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("request accepted during store clear");

    a_queue_empty_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !q_nonempty)
        else $error("queue holds a request during store clear");

    a_err_zero_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_err) |-> (o_total == '0))
        else $error("index error with nonzero bin total");

    a_outside_no_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_cls != CLS_IN) |-> (o_total == '0 && o_chosen == '0 && !o_err))
        else $error("out-of-range sample reported a bin");

endmodule
`default_nettype wire
